// ===== rtl/wsp_pkg.sv =====
// wsp_pkg: shared types, codes and helpers for the RIFF/WAVE stereo PCM parser.
// Used by wsp_core, wsp_out_buf and wav_stream_to_stereo_pcm_top; no dependencies.
package wsp_pkg;

  // result kinds (m_tuser)
  localparam logic [1:0] KIND_FORMAT = 2'd0;
  localparam logic [1:0] KIND_PAIR   = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_BAD_TAG  = 2'd1;
  localparam logic [1:0] ERR_WIDTH    = 2'd2;
  localparam logic [1:0] ERR_NO_FMT   = 2'd3;

  // four-character tags, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  // fmt chunk field offsets
  localparam logic [31:0] FMT_OFS_CH_LO   = 32'd2;
  localparam logic [31:0] FMT_OFS_CH_HI   = 32'd3;
  localparam logic [31:0] FMT_OFS_RATE    = 32'd4;
  localparam logic [31:0] FMT_OFS_RATE_END = 32'd8;
  localparam logic [31:0] FMT_OFS_BITS_LO = 32'd14;
  localparam logic [31:0] FMT_OFS_BITS_HI = 32'd15;

  // header: RIFF at 0..3, size at 4..7, WAVE at 8..11
  localparam logic [3:0] HDR_WAVE_OFS = 4'd8;
  localparam logic [3:0] HDR_LAST_OFS = 4'd11;

  // chunk codes held between tag and size fields
  localparam logic [1:0] CHUNK_OTHER = 2'd0;
  localparam logic [1:0] CHUNK_FMT   = 2'd1;
  localparam logic [1:0] CHUNK_DATA  = 2'd2;

  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 104;
  localparam int OUT_USER_W = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic [31:0]        rate_hz;
    logic [15:0]        num_channels;
    logic [15:0]        sample_bits;
    logic [1:0]         error_code;
  } wsp_result_t;

  // unsigned 8-bit sample to signed 16-bit: (b - 128) << 8
  function automatic logic [15:0] widen8(input logic [7:0] b);
    widen8 = {~b[7], b[6:0], 8'h00};
  endfunction

endpackage

// ===== rtl/wsp_core.sv =====
// wsp_core: chunk walker, format latches, sample assembly; one byte per fired cycle.
// Depends on wsp_pkg.
module wsp_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               fire,
  input  logic [7:0]         data_byte,
  input  logic               last_byte,
  output logic               res_valid,
  output wsp_pkg::wsp_result_t res
);
  import wsp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER, PH_ID, PH_SIZE, PH_FMT, PH_DATA, PH_SKIP, PH_PAD, PH_HALT
  } phase_t;

  phase_t      phase, phase_next;
  logic [31:0] byte_in_field, byte_in_field_next;
  logic [31:0] chunk_length, chunk_length_next;
  logic [31:0] tag_shift, tag_shift_next;
  logic [31:0] rate_store, rate_store_next;
  logic [15:0] channels_store, channels_store_next;
  logic [15:0] bits_store, bits_store_next;
  logic [2:0]  frame_bytes, frame_bytes_next;
  logic [1:0]  frame_index, frame_index_next;
  logic        format_seen, format_seen_next;

  logic        do_end;
  logic        emit;
  logic [1:0]  kind;
  logic [1:0]  err;
  logic [15:0] left_s, right_s;
  logic [3:0]  hdr_ofs;
  logic        hdr_bad;
  logic [31:0] shifted;
  logic [31:0] bif_inc;
  logic        width_ok;
  logic        halt;

  assign shifted = {data_byte, tag_shift[31:8]};
  assign bif_inc = byte_in_field + 32'd1;
  assign hdr_ofs = byte_in_field[3:0];

  always_comb begin
    phase_next          = phase;
    byte_in_field_next  = byte_in_field;
    chunk_length_next   = chunk_length;
    tag_shift_next      = tag_shift;
    rate_store_next     = rate_store;
    channels_store_next = channels_store;
    bits_store_next     = bits_store;
    frame_bytes_next    = frame_bytes;
    frame_index_next    = frame_index;
    format_seen_next    = format_seen;
    do_end   = 1'b0;
    emit     = 1'b0;
    kind     = KIND_FORMAT;
    err      = ERR_NONE;
    left_s   = 16'd0;
    right_s  = 16'd0;
    hdr_bad  = 1'b0;
    width_ok = 1'b0;
    halt     = 1'b0;

    case (phase)
      PH_HEADER: begin
        hdr_bad = (hdr_ofs < 4'd4 && data_byte != TAG_RIFF[{hdr_ofs[1:0], 3'b000} +: 8]) ||
                  (hdr_ofs >= HDR_WAVE_OFS && hdr_ofs <= HDR_LAST_OFS &&
                   data_byte != TAG_WAVE[{hdr_ofs[1:0], 3'b000} +: 8]);
        if (hdr_bad) begin
          emit       = 1'b1;
          kind       = KIND_ERROR;
          err        = ERR_BAD_TAG;
          phase_next = PH_HALT;
        end else if (hdr_ofs >= HDR_LAST_OFS) begin
          phase_next         = PH_ID;
          byte_in_field_next = 32'd0;
          tag_shift_next     = 32'd0;
        end else begin
          byte_in_field_next = {28'd0, hdr_ofs} + 32'd1;
        end
      end
      PH_ID: begin
        tag_shift_next = shifted;
        if (byte_in_field >= 32'd3) begin
          if (shifted == TAG_FMT)       chunk_length_next = {30'd0, CHUNK_FMT};
          else if (shifted == TAG_DATA) chunk_length_next = {30'd0, CHUNK_DATA};
          else                          chunk_length_next = {30'd0, CHUNK_OTHER};
          byte_in_field_next = 32'd0;
          tag_shift_next     = 32'd0;
          if (shifted == TAG_DATA && !format_seen) begin
            emit       = 1'b1;
            kind       = KIND_ERROR;
            err        = ERR_NO_FMT;
            phase_next = PH_HALT;
          end else begin
            phase_next = PH_SIZE;
          end
        end else begin
          byte_in_field_next = bif_inc;
        end
      end
      PH_SIZE: begin
        tag_shift_next = shifted;
        if (byte_in_field >= 32'd3) begin
          chunk_length_next  = shifted;
          byte_in_field_next = 32'd0;
          tag_shift_next     = 32'd0;
          frame_index_next   = 2'd0;
          if (chunk_length[1:0] == CHUNK_FMT) begin
            phase_next          = PH_FMT;
            rate_store_next     = 32'd0;
            channels_store_next = 16'd0;
            bits_store_next     = 16'd0;
            format_seen_next    = 1'b0;
          end else if (chunk_length[1:0] == CHUNK_DATA) begin
            phase_next = PH_DATA;
            case ({bits_store == 16'd8, channels_store == 16'd1})
              2'b11:   frame_bytes_next = 3'd1;
              2'b00:   frame_bytes_next = 3'd4;
              default: frame_bytes_next = 3'd2;
            endcase
          end else begin
            phase_next = PH_SKIP;
          end
          do_end = (shifted == 32'd0);
        end else begin
          byte_in_field_next = bif_inc;
        end
      end
      PH_FMT: begin
        if (byte_in_field == FMT_OFS_CH_LO)      channels_store_next[7:0]  = data_byte;
        else if (byte_in_field == FMT_OFS_CH_HI) channels_store_next[15:8] = data_byte;
        else if (byte_in_field >= FMT_OFS_RATE && byte_in_field < FMT_OFS_RATE_END)
          rate_store_next[{byte_in_field[1:0], 3'b000} +: 8] = data_byte;
        else if (byte_in_field == FMT_OFS_BITS_LO) bits_store_next[7:0]  = data_byte;
        else if (byte_in_field == FMT_OFS_BITS_HI) bits_store_next[15:8] = data_byte;
        byte_in_field_next = bif_inc;
        do_end = (bif_inc == chunk_length);
      end
      PH_DATA: begin
        tag_shift_next   = tag_shift | ({24'd0, data_byte} << {frame_index, 3'b000});
        frame_index_next = frame_index + 2'd1;
        if (frame_index_next == 2'd0 || {1'b0, frame_index_next} == frame_bytes) begin
          emit = 1'b1;
          kind = KIND_PAIR;
          if (frame_bytes == 3'd1) begin
            left_s  = widen8(tag_shift_next[7:0]);
            right_s = left_s;
          end else if (frame_bytes == 3'd4) begin
            left_s  = tag_shift_next[15:0];
            right_s = tag_shift_next[31:16];
          end else if (bits_store == 16'd8) begin
            left_s  = widen8(tag_shift_next[7:0]);
            right_s = widen8(tag_shift_next[15:8]);
          end else begin
            left_s  = tag_shift_next[15:0];
            right_s = tag_shift_next[15:0];
          end
          frame_index_next = 2'd0;
          tag_shift_next   = 32'd0;
        end
        byte_in_field_next = bif_inc;
        do_end = (bif_inc == chunk_length);
      end
      PH_SKIP: begin
        byte_in_field_next = bif_inc;
        do_end = (bif_inc == chunk_length);
      end
      PH_PAD: begin
        phase_next         = PH_ID;
        byte_in_field_next = 32'd0;
        tag_shift_next     = 32'd0;
      end
      default: ;
    endcase

    // end of a chunk body: fmt report or width error (halts), else pad or next tag
    if (do_end) begin
      if (phase_next == PH_FMT) begin
        width_ok = (bits_store_next == 16'd8) || (bits_store_next == 16'd16);
        emit     = 1'b1;
        if (width_ok) begin
          format_seen_next = 1'b1;
          kind = KIND_FORMAT;
        end else begin
          format_seen_next = 1'b0;
          kind = KIND_ERROR;
          err  = ERR_WIDTH;
          halt = 1'b1;
        end
      end
      if (halt)                       phase_next = PH_HALT;
      else if (chunk_length_next[0])  phase_next = PH_PAD;
      else                            phase_next = PH_ID;
      byte_in_field_next = 32'd0;
      tag_shift_next     = 32'd0;
      frame_index_next   = 2'd0;
    end
  end

  assign res_valid = fire && emit;

  always_comb begin
    res.kind          = kind;
    res.left_sample   = left_s;
    res.right_sample  = right_s;
    res.rate_hz       = rate_store_next;
    res.num_channels  = channels_store_next;
    res.sample_bits   = bits_store_next;
    res.error_code    = err;
  end

  always_ff @(posedge clk) begin
    if (rst || (fire && last_byte)) begin
      phase          <= PH_HEADER;
      byte_in_field  <= 32'd0;
      chunk_length   <= 32'd0;
      tag_shift      <= 32'd0;
      rate_store     <= 32'd0;
      channels_store <= 16'd0;
      bits_store     <= 16'd0;
      frame_bytes    <= 3'd0;
      frame_index    <= 2'd0;
      format_seen    <= 1'b0;
    end else if (fire) begin
      phase          <= phase_next;
      byte_in_field  <= byte_in_field_next;
      chunk_length   <= chunk_length_next;
      tag_shift      <= tag_shift_next;
      rate_store     <= rate_store_next;
      channels_store <= channels_store_next;
      bits_store     <= bits_store_next;
      frame_bytes    <= frame_bytes_next;
      frame_index    <= frame_index_next;
      format_seen    <= format_seen_next;
    end
  end

  // error results always carry a code
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_ERROR) |-> res.error_code != ERR_NONE)
    else $error("error result without code");

  // samples are zero outside pair results
  a_zero_samples: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind != KIND_PAIR) |-> (res.left_sample == 16'sd0 &&
                                             res.right_sample == 16'sd0))
    else $error("non-pair result with samples");

  // a halted parser stays silent
  a_halt_quiet: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == PH_HALT) |-> !res_valid)
    else $error("result while halted");

  // an error halts the parser unless the file ends there
  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    (fire && !last_byte && res_valid && res.kind == KIND_ERROR) |=> phase == PH_HALT)
    else $error("error did not halt parser");

  // pairs only come from a data chunk after a good format
  a_pair_fmt: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.kind == KIND_PAIR) |-> (phase == PH_DATA && format_seen))
    else $error("pair outside data chunk");

endmodule

// ===== rtl/wsp_out_buf.sv =====
// wsp_out_buf: result register on the master side, takes a new item while the old one leaves.
// Depends on wsp_pkg.
module wsp_out_buf (
  input  logic                clk,
  input  logic                rst,
  input  logic                load,
  input  wsp_pkg::wsp_result_t load_res,
  input  logic                tready,
  output logic                tvalid,
  output wsp_pkg::wsp_result_t res,
  output logic                can_take
);
  import wsp_pkg::*;

  assign can_take = !tvalid || tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
    end else if (load) begin
      tvalid <= 1'b1;
    end else if (tready) begin
      tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= load_res;
    end
  end

endmodule

// ===== rtl/wav_stream_to_stereo_pcm_top.sv =====
// wav_stream_to_stereo_pcm_top: RIFF/WAVE byte stream to 16-bit stereo PCM pairs.
// Depends on wsp_pkg, wsp_core, wsp_out_buf.
//
//   channel   | signals                          | item
//   ----------+----------------------------------+-----------------------------------
//   input     | s_tvalid s_tready s_tdata s_tlast| one file byte, tlast on final byte
//   output    | m_tvalid m_tready m_tdata m_tuser| format report, sample pair or error
//
// Flow: one byte per clock sustained while the output register can take
//   results; a byte is held in the input register, is parsed there and its
//   result (if any) lands in the output register, where m_tvalid rises.
// Reset: rst (synchronous) returns the parser to the RIFF header; tlast on a
//   byte does the same after that byte is parsed.
// Stalls: a low m_tready stops parsing once the output register is full;
//   s_tready then drops after the input register fills.
module wav_stream_to_stereo_pcm_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [wsp_pkg::IN_DATA_W-1:0]     s_tdata,  // [7:0] data_byte
  input  logic                              s_tlast,  // last_byte
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [15:0] left_sample, [31:16] right_sample, [63:32] rate_hz,
  // [79:64] num_channels, [95:80] sample_bits, [97:96] error_code, [103:98] zero
  output logic [wsp_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [wsp_pkg::OUT_USER_W-1:0]    m_tuser   // [1:0] kind
);
  import wsp_pkg::*;

  // input register
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_last;

  logic        fire;
  logic        out_can_take;
  logic        res_valid;
  wsp_result_t core_res;
  wsp_result_t out_res;

  // a held byte is parsed whenever the result register can take its result
  assign fire     = in_valid && out_can_take;
  assign s_tready = !in_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_last <= s_tlast;
    end
  end

  wsp_core u_core (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .data_byte (in_byte),
    .last_byte (in_last),
    .res_valid (res_valid),
    .res       (core_res)
  );

  wsp_out_buf u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (res_valid),
    .load_res (core_res),
    .tready   (m_tready),
    .tvalid   (m_tvalid),
    .res      (out_res),
    .can_take (out_can_take)
  );

  assign m_tuser = out_res.kind;
  assign m_tdata = {6'd0, out_res.error_code, out_res.sample_bits, out_res.num_channels,
                    out_res.rate_hz, out_res.right_sample, out_res.left_sample};

endmodule
